// File: hw/rtl/pns_pkg.sv
// ----------------------------------------------------------------------------
// pns_pkg
// Shared types, constants and SHA-256 helpers for the nonce search block.
// ----------------------------------------------------------------------------
`default_nettype none

package pns_pkg;

  localparam int MAX_DATA_BYTES = 256;
  localparam int ADDR_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
  localparam int CNT_W  = $clog2(MAX_DATA_BYTES + 1);
  localparam int POS_W  = $clog2(MAX_DATA_BYTES + 80);

  localparam logic [1:0] REG_DIFFICULTY = 2'd0;
  localparam logic [1:0] REG_START      = 2'd1;
  localparam logic [1:0] REG_LIMIT      = 2'd2;

  localparam logic [255:0] INIT_H = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_IGO, ST_IRUN, ST_OGO, ST_ORUN, ST_CHECK, ST_EMIT
  } pns_state_t;

  typedef struct packed {
    logic         start;
    logic [255:0] chain;
    logic [511:0] block;
  } pns_core_req_t;

  typedef struct packed {
    logic         done;
    logic [255:0] digest;
  } pns_core_rsp_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pns_ifs.sv
// ----------------------------------------------------------------------------
// pns_ifs
// Channel interfaces: data input, result output and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface pns_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       data_last;
  modport source (output valid, data_byte, data_last, input ready);
  modport sink (input valid, data_byte, data_last, output ready);
endinterface

interface pns_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] found_nonce;
  logic [31:0] hashes_done;
  logic        data_overflow;
  logic [1:0]  digest_index;
  logic [63:0] digest_word;
  logic        result_last;
  modport source (output valid, found, found_nonce, hashes_done, data_overflow,
                  digest_index, digest_word, result_last, input ready);
  modport sink (input valid, found, found_nonce, hashes_done, data_overflow,
                digest_index, digest_word, result_last, output ready);
endinterface

interface pns_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pns_sha_core.sv
// ----------------------------------------------------------------------------
// pns_sha_core
// SHA-256 compression of one 512-bit block, one round per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pns_sha_core
  import pns_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pns_core_req_t req,
  output pns_core_rsp_t      rsp
);

  logic [31:0] v [8];
  logic [31:0] hsave [8];
  logic [31:0] w [16];
  logic [5:0]  rnd;
  logic        busy;
  logic        done;
  logic [31:0] t1, t2, wnew;

  always_comb begin
    t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[rnd] + w[0];
    t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    wnew = ssig1(w[14]) + w[9] + ssig0(w[1]) + w[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      for (int i = 0; i < 8; i++) begin
        v[i]     <= req.chain[255 - 32*i -: 32];
        hsave[i] <= req.chain[255 - 32*i -: 32];
      end
      for (int i = 0; i < 16; i++) w[i] <= req.block[511 - 32*i -: 32];
    end else if (busy) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= wnew;
    end
  end

  always_comb begin
    rsp.done = done;
    for (int i = 0; i < 8; i++) rsp.digest[255 - 32*i -: 32] = hsave[i] + v[i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/pow_nonce_search_top.sv
// ----------------------------------------------------------------------------
// pow_nonce_search_top
// Double SHA-256 nonce search over buffered block data.
// ----------------------------------------------------------------------------
// channel     dir   beat
// data_in     in    data_byte, data_last
// result_out  out   found, found_nonce, hashes_done, data_overflow,
//                   digest_index, digest_word, result_last
// cfg         in    index, data
//
// Data bytes are taken while idle. After the last byte each nonce runs
// load, core start and rounds per inner block, then core start and
// rounds for the outer block and a compare, all on one shared round
// unit. Four result beats follow. Reset clears control state; the data
// buffer holds no reset. data_in stalls during search and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module pow_nonce_search_top
  import pns_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  pns_in_if.sink     data_in,
  pns_out_if.source  result_out,
  pns_cfg_if.sink    cfg
);

  pns_state_t state, state_next;

  logic [31:0] difficulty, nonce_base, iter_limit;
  logic [7:0]  mem [MAX_DATA_BYTES];
  logic [7:0]  memq;
  logic [CNT_W-1:0] byte_count;
  logic        overflow;
  logic [CNT_W-1:0] n;
  logic [POS_W-1:0] p, padded, len;
  logic [6:0]  ic;
  logic [5:0]  sc;
  logic        s1v, s1mem;
  logic [7:0]  s1byte, gen_byte;
  logic        gen_mem;
  logic [511:0] blk;
  logic [255:0] hs, idig, odig;
  logic [31:0] nonce, tries, limit_eff, win;
  logic [63:0] target, hv, bitlen, words [4];
  logic        found;
  logic [1:0]  k;
  logic [2:0]  d;
  logic        meets, last_try;
  logic        in_acc, out_acc;
  pns_core_req_t creq;
  pns_core_rsp_t crsp;

  pns_sha_core u_core (.clk(clk), .rst(rst), .req(creq), .rsp(crsp));

  assign cfg.ready = 1'b1;
  assign in_acc  = data_in.valid && data_in.ready;
  assign out_acc = result_out.valid && result_out.ready;

  always_comb begin
    len    = POS_W'(n) + POS_W'(4);
    bitlen = 64'(len) << 3;
    d      = 3'(padded - POS_W'(1) - p);
    gen_mem  = 1'b0;
    gen_byte = 8'h00;
    if (p < POS_W'(n)) begin
      gen_mem = 1'b1;
    end else if (p < len) begin
      gen_byte = 8'(nonce >> {3'(p - POS_W'(n)) & 3'd3, 3'b000});
    end else if (p == len) begin
      gen_byte = 8'h80;
    end else if (p >= padded - POS_W'(8)) begin
      gen_byte = 8'(bitlen >> {d, 3'b000});
    end
  end

  always_comb begin
    for (int j = 0; j < 8; j++) hv[8*j +: 8] = odig[255 - 8*j -: 8];
    for (int q = 0; q < 4; q++) begin
      for (int j = 0; j < 8; j++) words[q][8*j +: 8] = odig[255 - 8*(8*q + j) -: 8];
    end
    meets    = hv <= target;
    last_try = (tries + 32'd1) == limit_eff;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_acc && data_in.data_last) state_next = ST_LOAD;
      ST_LOAD:  if (s1v && sc == 6'd63) state_next = ST_IGO;
      ST_IGO:   state_next = ST_IRUN;
      ST_IRUN:  if (crsp.done) state_next = (p == padded) ? ST_OGO : ST_LOAD;
      ST_OGO:   state_next = ST_ORUN;
      ST_ORUN:  if (crsp.done) state_next = ST_CHECK;
      ST_CHECK: state_next = (meets || last_try) ? ST_EMIT : ST_LOAD;
      ST_EMIT:  if (out_acc && k == 2'd3) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    data_in.ready = state == ST_IDLE;
    result_out.valid = state == ST_EMIT;
    creq.start = (state == ST_IGO) || (state == ST_OGO);
    creq.chain = (state == ST_OGO) ? INIT_H : hs;
    creq.block = (state == ST_OGO) ? {idig, 8'h80, 184'd0, 64'd256} : blk;
    result_out.found         = found;
    result_out.found_nonce   = win;
    result_out.hashes_done   = tries;
    result_out.data_overflow = overflow;
    result_out.digest_index  = k;
    result_out.digest_word   = found ? words[k] : 64'd0;
    result_out.result_last   = k == 2'd3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      difficulty <= '0;
      nonce_base <= '0;
      iter_limit <= '0;
      byte_count <= '0;
      overflow <= 1'b0;
      nonce <= '0;
      tries <= '0;
      s1v <= 1'b0;
      k <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_DIFFICULTY: difficulty  <= cfg.data;
          REG_START:      nonce_base  <= cfg.data;
          REG_LIMIT:      iter_limit  <= cfg.data;
          default: ;
        endcase
      end
      s1v <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (byte_count < CNT_W'(MAX_DATA_BYTES)) byte_count <= byte_count + CNT_W'(1);
            else overflow <= 1'b1;
            if (data_in.data_last) begin
              nonce <= nonce_base;
              tries <= '0;
            end
          end
        end
        ST_LOAD: s1v <= ic < 7'd64;
        ST_CHECK: begin
          tries <= tries + 32'd1;
          if (!meets && !last_try) nonce <= nonce + 32'd1;
        end
        ST_EMIT: begin
          if (out_acc) begin
            k <= k + 2'd1;
            if (k == 2'd3) begin
              byte_count <= '0;
              overflow <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    memq <= mem[p[ADDR_W-1:0]];
    if (in_acc && byte_count < CNT_W'(MAX_DATA_BYTES)) begin
      mem[byte_count[ADDR_W-1:0]] <= data_in.data_byte;
    end
    unique case (state)
      ST_IDLE: begin
        if (in_acc && data_in.data_last) begin
          n <= (byte_count < CNT_W'(MAX_DATA_BYTES)) ? byte_count + CNT_W'(1) : byte_count;
          padded <= ((((byte_count < CNT_W'(MAX_DATA_BYTES)) ?
                       POS_W'(byte_count) + POS_W'(1) : POS_W'(byte_count))
                      + POS_W'(76)) >> 6) << 6;
          limit_eff <= (iter_limit == 32'd0) ? 32'hffffffff : iter_limit;
          if (difficulty[31:24] <= 8'd3) begin
            target <= {40'd0, difficulty[23:0]} >> {2'd3 - difficulty[25:24], 3'b000};
          end else if (difficulty[31:24] >= 8'd11) begin
            target <= '0;
          end else begin
            target <= {40'd0, difficulty[23:0]} << {difficulty[26:24] - 3'd3, 3'b000};
          end
          hs <= INIT_H;
          p  <= '0;
          ic <= '0;
          sc <= '0;
          found <= 1'b0;
          win <= '0;
        end
      end
      ST_LOAD: begin
        if (ic < 7'd64) begin
          s1mem  <= gen_mem;
          s1byte <= gen_byte;
          p  <= p + POS_W'(1);
          ic <= ic + 7'd1;
        end
        if (s1v) begin
          blk <= {blk[503:0], s1mem ? memq : s1byte};
          sc  <= sc + 6'd1;
        end
      end
      ST_IRUN: begin
        if (crsp.done) begin
          hs <= crsp.digest;
          idig <= crsp.digest;
          ic <= '0;
          sc <= '0;
        end
      end
      ST_ORUN: if (crsp.done) odig <= crsp.digest;
      ST_CHECK: begin
        if (meets) begin
          found <= 1'b1;
          win <= nonce;
        end else if (!last_try) begin
          hs <= INIT_H;
          p  <= '0;
          ic <= '0;
          sc <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
